FILE: rtl/tti_pkg.sv
// ----------------------------------------------------------------------------
// Table time interpolator package
// Item types, state codes and shared constants of the interpolator.
// ----------------------------------------------------------------------------
package tti_pkg;

   localparam int NUM_CH = 10;
   localparam int ALU_W  = 66;

   localparam logic       REQ_LOAD     = 1'b0;
   localparam logic       REQ_QUERY    = 1'b1;
   localparam logic [3:0] COL_TIME     = 4'd0;
   localparam logic [3:0] CH_NONE      = 4'd0;
   localparam logic       STATUS_OK    = 1'b0;
   localparam logic       STATUS_RANGE = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [9:0]        entry_index;
      logic [3:0]        column;
      logic signed [63:0] load_value;
      logic signed [63:0] query_time;
   } req_item_type;

   typedef struct packed {
      logic [3:0]         channel;
      logic signed [63:0] result_value;
      logic               status;
      logic               last;
   } rsp_item_type;

   typedef struct packed {
      logic invert;
      logic cin;
   } alu_op_type;

   localparam alu_op_type ALU_ADD = '{invert: 1'b0, cin: 1'b0};
   localparam alu_op_type ALU_SUB = '{invert: 1'b1, cin: 1'b1};

   typedef struct packed {
      logic done;
      logic sticky;
   } mul_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_FIRST,
      ST_RD_LAST,
      ST_CHK_LAST,
      ST_SEARCH,
      ST_CMP,
      ST_NUM,
      ST_DEN,
      ST_DIV,
      ST_RD_Y0,
      ST_RD_Y1,
      ST_SIGN,
      ST_MAG,
      ST_MUL,
      ST_EMIT,
      ST_EMIT_OOR
   } state_type;

endpackage

FILE: rtl/table_time_interpolator_core.sv
// ----------------------------------------------------------------------------
// Table time interpolator core
// Sampled track with binary interval search, serial fraction division and
// per-channel linear interpolation in signed Q32.32.
// ----------------------------------------------------------------------------
// A load item writes one table word and leaves the core idle for the next
// item. A query item is worked on alone: the ends of the table are read and
// checked, the binary search halves the interval with a read and a compare
// step over the time memory read port until its ends are adjacent entries,
// the fraction comes from a restoring divider at one bit a cycle (FRAC_BITS
// bits), and each of the ten channels then takes two sample memory reads, a
// sign and a magnitude step on the shared adder, the 64x16 multiplier with a
// product and an accumulate step per 16-bit fraction chunk and a completion
// flag, and one emit step. An out-of-range query gives a single result with
// range status. Results leave through an output register, and the sequencer
// stalls only when that register is full and not being taken.
// ----------------------------------------------------------------------------
module table_time_interpolator_core #(
   parameter int TABLE_DEPTH = 1024,
   parameter int FRAC_BITS   = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tti_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tti_pkg::rsp_item_type rsp_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [10:0]           csr_data
);

   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int SAW = $clog2(TABLE_DEPTH * tti_pkg::NUM_CH);
   localparam int DCW = $clog2(FRAC_BITS);
   localparam int W   = tti_pkg::ALU_W;

   function automatic logic [W-1:0] sext(input logic [63:0] x);
      sext = {{(W-64){x[63]}}, x};
   endfunction

   function automatic logic [W-1:0] zext(input logic [63:0] x);
      zext = {{(W-64){1'b0}}, x};
   endfunction

   tti_pkg::state_type     state_ff, state_in;
   logic [10:0]            count_ff, count_in;
   logic [63:0]            qtime_ff, qtime_in;
   logic [AW-1:0]          lo_ff, lo_in;
   logic [AW-1:0]          hi_ff, hi_in;
   logic [AW-1:0]          mid_ff, mid_in;
   logic [63:0]            tlo_ff, tlo_in;
   logic [63:0]            thi_ff, thi_in;
   logic                   oor_ff, oor_in;
   logic [63:0]            rem_ff, rem_in;
   logic [63:0]            den_ff, den_in;
   logic [FRAC_BITS-1:0]   frac_ff, frac_in;
   logic [DCW-1:0]         div_cnt_ff, div_cnt_in;
   logic [3:0]             ch_ff, ch_in;
   logic [63:0]            y0_ff, y0_in;
   logic [63:0]            y1_ff, y1_in;
   logic                   neg_ff, neg_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   tti_pkg::rsp_item_type  rsp_item_ff, rsp_item_in;

   logic                   req_acc;
   logic                   load_ok;
   logic                   out_free;
   logic [AW-1:0]          last_idx;
   logic [AW:0]            mid_sum;
   logic [AW-1:0]          span;
   logic                   div_ge;

   logic [W-1:0]           alu_a, alu_b, alu_sum;
   tti_pkg::alu_op_type    alu_op;
   logic                   alu_neg;

   logic                   mul_start;
   logic [63:0]            mul_quot;
   tti_pkg::mul_status_type mul_stat;

   logic                   t_we, s_we;
   logic [AW-1:0]          t_waddr, t_raddr;
   logic [SAW-1:0]         s_waddr, s_raddr;
   logic [63:0]            t_rdata, s_rdata;

   tti_alu u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .op  (alu_op),
      .sum (alu_sum)
   );

   tti_mul #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .mag   (alu_sum[63:0]),
      .frac  (frac_ff),
      .quot  (mul_quot),
      .stat  (mul_stat)
   );

   tti_store #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .t_we    (t_we),
      .t_waddr (t_waddr),
      .t_wdata (req_item.load_value),
      .t_raddr (t_raddr),
      .t_rdata (t_rdata),
      .s_we    (s_we),
      .s_waddr (s_waddr),
      .s_wdata (req_item.load_value),
      .s_raddr (s_raddr),
      .s_rdata (s_rdata)
   );

   assign req_ready = (state_ff == tti_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign req_acc  = req_valid && req_ready;
   assign load_ok  = req_acc && (req_item.req_type == tti_pkg::REQ_LOAD)
                     && (32'(req_item.entry_index) < TABLE_DEPTH);
   assign t_we     = load_ok && (req_item.column == tti_pkg::COL_TIME);
   assign s_we     = load_ok && (req_item.column != tti_pkg::COL_TIME)
                     && (32'(req_item.column) <= tti_pkg::NUM_CH);
   assign t_waddr  = AW'(req_item.entry_index);
   assign s_waddr  = SAW'(32'(req_item.entry_index) * tti_pkg::NUM_CH
                          + 32'(req_item.column) - 32'd1);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign alu_neg  = alu_sum[W-1];
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign span     = hi_ff - lo_ff;
   assign div_ge   = !alu_neg;

   always_comb begin
      priority if (count_ff < 11'd2) begin
         last_idx = AW'(1);
      end else if (32'(count_ff) > TABLE_DEPTH) begin
         last_idx = AW'(TABLE_DEPTH - 1);
      end else begin
         last_idx = AW'(32'(count_ff) - 32'd1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = csr_valid ? csr_data : count_ff;
      qtime_in     = qtime_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      tlo_in       = tlo_ff;
      thi_in       = thi_ff;
      oor_in       = oor_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      frac_in      = frac_ff;
      div_cnt_in   = div_cnt_ff;
      ch_in        = ch_ff;
      y0_in        = y0_ff;
      y1_in        = y1_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      alu_a        = '0;
      alu_b        = '0;
      alu_op       = tti_pkg::ALU_ADD;
      mul_start    = 1'b0;
      t_raddr      = '0;
      s_raddr      = SAW'(32'(lo_ff) * tti_pkg::NUM_CH + 32'(ch_ff));

      unique case (state_ff)
         tti_pkg::ST_IDLE: begin
            if (req_acc && (req_item.req_type == tti_pkg::REQ_QUERY)) begin
               qtime_in = req_item.query_time;
               state_in = tti_pkg::ST_RD_FIRST;
            end
         end
         tti_pkg::ST_RD_FIRST: begin
            state_in = tti_pkg::ST_RD_LAST;
         end
         tti_pkg::ST_RD_LAST: begin
            t_raddr  = last_idx;
            alu_a    = sext(qtime_ff);
            alu_b    = sext(t_rdata);
            alu_op   = tti_pkg::ALU_SUB;
            oor_in   = alu_neg;
            tlo_in   = t_rdata;
            state_in = tti_pkg::ST_CHK_LAST;
         end
         tti_pkg::ST_CHK_LAST: begin
            alu_a  = sext(qtime_ff);
            alu_b  = sext(t_rdata);
            alu_op = tti_pkg::ALU_SUB;
            oor_in = oor_ff || !alu_neg;
            thi_in = t_rdata;
            lo_in  = '0;
            hi_in  = last_idx;
            state_in = (oor_ff || !alu_neg) ? tti_pkg::ST_EMIT_OOR : tti_pkg::ST_SEARCH;
         end
         tti_pkg::ST_SEARCH: begin
            if (span > AW'(1)) begin
               t_raddr  = mid_sum[AW:1];
               mid_in   = mid_sum[AW:1];
               state_in = tti_pkg::ST_CMP;
            end else begin
               state_in = tti_pkg::ST_NUM;
            end
         end
         tti_pkg::ST_CMP: begin
            alu_a  = sext(qtime_ff);
            alu_b  = sext(t_rdata);
            alu_op = tti_pkg::ALU_SUB;
            if (alu_neg) begin
               hi_in  = mid_ff;
               thi_in = t_rdata;
            end else begin
               lo_in  = mid_ff;
               tlo_in = t_rdata;
            end
            state_in = tti_pkg::ST_SEARCH;
         end
         tti_pkg::ST_NUM: begin
            alu_a    = zext(qtime_ff);
            alu_b    = zext(tlo_ff);
            alu_op   = tti_pkg::ALU_SUB;
            rem_in   = alu_sum[63:0];
            state_in = tti_pkg::ST_DEN;
         end
         tti_pkg::ST_DEN: begin
            alu_a      = zext(thi_ff);
            alu_b      = zext(tlo_ff);
            alu_op     = tti_pkg::ALU_SUB;
            den_in     = alu_sum[63:0];
            div_cnt_in = '0;
            state_in   = tti_pkg::ST_DIV;
         end
         tti_pkg::ST_DIV: begin
            alu_a      = {{(W-65){1'b0}}, rem_ff, 1'b0};
            alu_b      = zext(den_ff);
            alu_op     = tti_pkg::ALU_SUB;
            rem_in     = div_ge ? alu_sum[63:0] : {rem_ff[62:0], 1'b0};
            frac_in    = {frac_ff[FRAC_BITS-2:0], div_ge};
            div_cnt_in = div_cnt_ff + DCW'(1);
            if (div_cnt_ff == DCW'(FRAC_BITS - 1)) begin
               ch_in    = '0;
               state_in = tti_pkg::ST_RD_Y0;
            end
         end
         tti_pkg::ST_RD_Y0: begin
            state_in = tti_pkg::ST_RD_Y1;
         end
         tti_pkg::ST_RD_Y1: begin
            s_raddr  = SAW'(32'(hi_ff) * tti_pkg::NUM_CH + 32'(ch_ff));
            y0_in    = s_rdata;
            state_in = tti_pkg::ST_SIGN;
         end
         tti_pkg::ST_SIGN: begin
            alu_a    = sext(s_rdata);
            alu_b    = sext(y0_ff);
            alu_op   = tti_pkg::ALU_SUB;
            y1_in    = s_rdata;
            neg_in   = alu_neg;
            state_in = tti_pkg::ST_MAG;
         end
         tti_pkg::ST_MAG: begin
            alu_a     = neg_ff ? zext(y0_ff) : zext(y1_ff);
            alu_b     = neg_ff ? zext(y1_ff) : zext(y0_ff);
            alu_op    = tti_pkg::ALU_SUB;
            mul_start = 1'b1;
            state_in  = tti_pkg::ST_MUL;
         end
         tti_pkg::ST_MUL: begin
            if (mul_stat.done) begin
               state_in = tti_pkg::ST_EMIT;
            end
         end
         tti_pkg::ST_EMIT: begin
            alu_a      = zext(y0_ff);
            alu_b      = zext(mul_quot);
            alu_op.invert = neg_ff;
            alu_op.cin    = neg_ff && !mul_stat.sticky;
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_item_in.channel       = ch_ff + 4'd1;
               rsp_item_in.result_value  = alu_sum[63:0];
               rsp_item_in.status        = tti_pkg::STATUS_OK;
               rsp_item_in.last          = (ch_ff == 4'(tti_pkg::NUM_CH - 1));
               if (ch_ff == 4'(tti_pkg::NUM_CH - 1)) begin
                  state_in = tti_pkg::ST_IDLE;
               end else begin
                  ch_in    = ch_ff + 4'd1;
                  state_in = tti_pkg::ST_RD_Y0;
               end
            end
         end
         tti_pkg::ST_EMIT_OOR: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.channel      = tti_pkg::CH_NONE;
               rsp_item_in.result_value = '0;
               rsp_item_in.status       = tti_pkg::STATUS_RANGE;
               rsp_item_in.last         = 1'b1;
               state_in                 = tti_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tti_pkg::ST_IDLE;
         count_ff     <= 11'd2;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qtime_ff    <= qtime_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      tlo_ff      <= tlo_in;
      thi_ff      <= thi_in;
      oor_ff      <= oor_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      frac_ff     <= frac_in;
      div_cnt_ff  <= div_cnt_in;
      ch_ff       <= ch_in;
      y0_ff       <= y0_in;
      y1_ff       <= y1_in;
      neg_ff      <= neg_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

FILE: rtl/tti_alu.sv
// ----------------------------------------------------------------------------
// Shared adder
// One wide add/subtract with operand inversion and carry in, used for every
// compare, difference, division step and final sum of the interpolator.
// ----------------------------------------------------------------------------
module tti_alu (
   input  logic [tti_pkg::ALU_W-1:0] a,
   input  logic [tti_pkg::ALU_W-1:0] b,
   input  tti_pkg::alu_op_type       op,
   output logic [tti_pkg::ALU_W-1:0] sum
);

   logic [tti_pkg::ALU_W-1:0] operand;

   assign operand = op.invert ? ~b : b;
   assign sum     = a + operand + tti_pkg::ALU_W'(op.cin);

endmodule

FILE: rtl/tti_mul.sv
// ----------------------------------------------------------------------------
// Chunked fraction multiplier
// Multiplies a 64-bit magnitude by the fraction sixteen bits at a time, shifts
// the fraction bits out and keeps a sticky bit of what was dropped.
// ----------------------------------------------------------------------------
module tti_mul #(
   parameter int FRAC_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [63:0]                mag,
   input  logic [FRAC_BITS-1:0]       frac,
   output logic [63:0]                quot,
   output tti_pkg::mul_status_type    stat
);

   localparam int CHUNK  = 16;
   localparam int NCHUNK = (FRAC_BITS + CHUNK - 1) / CHUNK;
   localparam int MW     = NCHUNK * CHUNK;
   localparam int PAD    = MW - FRAC_BITS;
   localparam int CW     = $clog2(NCHUNK + 1);

   logic              busy_ff, busy_in;
   logic              phase_ff, phase_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [63:0]       mag_ff, mag_in;
   logic [MW-1:0]     m_ff, m_in;
   logic [79:0]       prod_ff, prod_in;
   logic [64:0]       acc_ff, acc_in;
   logic              sticky_ff, sticky_in;
   logic [80:0]       sum;

   always_comb begin
      sum       = {16'b0, acc_ff} + {1'b0, prod_ff};
      busy_in   = busy_ff;
      phase_in  = phase_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mag_in    = mag_ff;
      m_in      = m_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      sticky_in = sticky_ff;
      if (start) begin
         busy_in   = 1'b1;
         phase_in  = 1'b0;
         cnt_in    = '0;
         mag_in    = mag;
         m_in      = MW'(frac) << PAD;
         acc_in    = '0;
         sticky_in = 1'b0;
      end else if (busy_ff) begin
         phase_in = !phase_ff;
         if (!phase_ff) begin
            prod_in = mag_ff * m_ff[CHUNK-1:0];
         end else begin
            acc_in    = sum[80:CHUNK];
            sticky_in = sticky_ff | (|sum[CHUNK-1:0]);
            m_in      = m_ff >> CHUNK;
            cnt_in    = cnt_ff + CW'(1);
            if (cnt_ff == CW'(NCHUNK - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff    <= mag_in;
      m_ff      <= m_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      sticky_ff <= sticky_in;
   end

   assign quot        = acc_ff[63:0];
   assign stat.done   = done_ff;
   assign stat.sticky = sticky_ff;

endmodule

FILE: rtl/tti_store.sv
// ----------------------------------------------------------------------------
// Table store
// Time memory and sample memory, one write and one registered read port each.
// ----------------------------------------------------------------------------
module tti_store #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                                                  clock,
   input  logic                                                  t_we,
   input  logic [$clog2(TABLE_DEPTH)-1:0]                        t_waddr,
   input  logic [63:0]                                           t_wdata,
   input  logic [$clog2(TABLE_DEPTH)-1:0]                        t_raddr,
   output logic [63:0]                                           t_rdata,
   input  logic                                                  s_we,
   input  logic [$clog2(TABLE_DEPTH*tti_pkg::NUM_CH)-1:0]        s_waddr,
   input  logic [63:0]                                           s_wdata,
   input  logic [$clog2(TABLE_DEPTH*tti_pkg::NUM_CH)-1:0]        s_raddr,
   output logic [63:0]                                           s_rdata
);

   logic [63:0] time_mem   [TABLE_DEPTH];
   logic [63:0] sample_mem [TABLE_DEPTH*tti_pkg::NUM_CH];

   always_ff @(posedge clock) begin
      if (t_we) begin
         time_mem[t_waddr] <= t_wdata;
      end
      t_rdata <= time_mem[t_raddr];
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         sample_mem[s_waddr] <= s_wdata;
      end
      s_rdata <= sample_mem[s_raddr];
   end

endmodule
